>>> design/awf_pkg.sv
`default_nettype none

package awf_pkg;

    // Data widths
    localparam int SAMPLE_WIDTH   = 24;
    localparam int STATE_WIDTH    = 48;
    localparam int COEF_FRAC_BITS = 30;
    localparam int NUM_SECTIONS   = 3;
    localparam int COEF_WIDTH     = 32;
    // Negated coefficient needs one more bit (minus the most negative code)
    localparam int NCOEF_WIDTH    = COEF_WIDTH + 1;
    localparam int SHIFT_WIDTH    = 6;
    localparam int NUM_COEFS      = 2 * NUM_SECTIONS;
    localparam int SEC_IDX_WIDTH  = 2;
    localparam int COEF_IDX_WIDTH = 3;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 32;

    // Multiplier split: state word taken as low and high halves
    localparam int MUL_LO_WIDTH   = STATE_WIDTH / 2;
    localparam int MUL_HI_WIDTH   = STATE_WIDTH - MUL_LO_WIDTH;
    localparam int MUL_A_WIDTH    = MUL_HI_WIDTH + 1;
    localparam int PP_WIDTH       = STATE_WIDTH + NCOEF_WIDTH;

    // Register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEN_A1_SEC0    = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEN_A2_SEC0    = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEN_A1_SEC1    = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEN_A2_SEC1    = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEN_A1_SEC2    = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEN_A2_SEC2    = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OUTPUT_GAIN    = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SECTION_SHIFTS = 3'd7;

    localparam logic [COEF_WIDTH-1:0] GAIN_RESET = 32'sd1073741824;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [NUM_COEFS-1:0][NCOEF_WIDTH-1:0]     nden;   // negated denominators
        logic [COEF_WIDTH-1:0]                     gain;
        logic [NUM_SECTIONS-1:0][SHIFT_WIDTH-1:0]  shifts;
    } t_cfg;

    // One history row per section
    typedef struct packed {
        logic [STATE_WIDTH-1:0] x1;
        logic [STATE_WIDTH-1:0] x2;
        logic [STATE_WIDTH-1:0] y1;
        logic [STATE_WIDTH-1:0] y2;
    } t_row;

    typedef enum logic [1:0] {
        MUL_HOLD = 2'd0,
        MUL_LO   = 2'd1,
        MUL_HI   = 2'd2,
        MUL_CLR  = 2'd3
    } t_mul_op;

endpackage

`default_nettype wire

>>> design/awf_cfg_regs.sv
`default_nettype none

module awf_cfg_regs (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [awf_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  wire logic [awf_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    output awf_pkg::t_cfg                             o_cfg
);

    awf_pkg::t_cfg r_cfg;
    logic [awf_pkg::NCOEF_WIDTH-1:0] n_nden;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Store feedback coefficients already negated
    assign n_nden = awf_pkg::NCOEF_WIDTH'(-$signed({i_cfg_data[awf_pkg::COEF_WIDTH-1],
                                                    i_cfg_data[awf_pkg::COEF_WIDTH-1:0]}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nden   <= '0;
            r_cfg.gain   <= awf_pkg::GAIN_RESET;
            r_cfg.shifts <= '0;
        end else if (i_cfg_valid) begin
            priority if (i_cfg_index == awf_pkg::REG_SECTION_SHIFTS) begin
                r_cfg.shifts <= i_cfg_data[awf_pkg::NUM_SECTIONS*awf_pkg::SHIFT_WIDTH-1:0];
            end else if (i_cfg_index == awf_pkg::REG_OUTPUT_GAIN) begin
                r_cfg.gain <= i_cfg_data[awf_pkg::COEF_WIDTH-1:0];
            end else begin
                r_cfg.nden[i_cfg_index] <= n_nden;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/awf_state_ram.sv
`default_nettype none

module awf_state_ram (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_rd_en,
    input  wire logic [awf_pkg::SEC_IDX_WIDTH-1:0]   i_rd_addr,
    output awf_pkg::t_row                            o_rd_data,
    input  wire logic                                i_wr_en,
    input  wire logic [awf_pkg::SEC_IDX_WIDTH-1:0]   i_wr_addr,
    input  wire awf_pkg::t_row                       i_wr_data
);

    awf_pkg::t_row mem [awf_pkg::NUM_SECTIONS];
    logic [awf_pkg::NUM_SECTIONS-1:0] r_vld;
    awf_pkg::t_row r_rd_data;
    logic r_rd_vld;

    // Row storage, one write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Valid bits: a row never written reads as zero history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

>>> design/awf_mul.sv
`default_nettype none

module awf_mul (
    input  wire logic                                      i_clk,
    input  wire awf_pkg::t_mul_op                          i_op,
    input  wire logic signed [awf_pkg::STATE_WIDTH-1:0]    i_y,
    input  wire logic signed [awf_pkg::NCOEF_WIDTH-1:0]    i_c,
    output logic signed [awf_pkg::STATE_WIDTH-1:0]         o_prod
);

    localparam int LO_W  = awf_pkg::MUL_LO_WIDTH;
    localparam int HI_W  = awf_pkg::MUL_HI_WIDTH;
    localparam int A_W   = awf_pkg::MUL_A_WIDTH;
    localparam int P_W   = A_W + awf_pkg::NCOEF_WIDTH;
    localparam int PP_W  = awf_pkg::PP_WIDTH;
    localparam int SW    = awf_pkg::STATE_WIDTH;
    localparam int FRAC  = awf_pkg::COEF_FRAC_BITS;

    logic signed [A_W-1:0]  op_a;
    logic signed [P_W-1:0]  pp;
    logic signed [PP_W-1:0] pp_ext;
    logic signed [PP_W-1:0] r_pp;
    logic [PP_W-FRAC-SW:0]  top_bits;

    // Pick the half of the state word: low half unsigned, high half signed
    always_comb begin
        if (i_op == awf_pkg::MUL_HI) begin
            op_a = A_W'(i_y[SW-1:LO_W]);
            op_a = $signed({i_y[SW-1], i_y[SW-1:LO_W]});
        end else begin
            op_a = $signed(A_W'(i_y[LO_W-1:0]));
        end
    end

    assign pp     = op_a * i_c;
    assign pp_ext = PP_W'(pp);

    // Accumulate partial products: low half first, then high half weighted
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            awf_pkg::MUL_LO:   r_pp <= pp_ext;
            awf_pkg::MUL_HI:   r_pp <= r_pp + (pp_ext <<< LO_W);
            awf_pkg::MUL_CLR:  r_pp <= '0;
            awf_pkg::MUL_HOLD: r_pp <= r_pp;
            default:           r_pp <= r_pp;
        endcase
    end

    // Floor shift by the fraction bits, saturate to the state width
    assign top_bits = r_pp[PP_W-1:FRAC+SW-1];

    always_comb begin
        if ((top_bits == '0) || (top_bits == '1)) begin
            o_prod = r_pp[FRAC+SW-1:FRAC];
        end else if (r_pp[PP_W-1]) begin
            o_prod = {1'b1, {(SW-1){1'b0}}};
        end else begin
            o_prod = {1'b0, {(SW-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

>>> design/a_weighting_filter_unit.sv
`default_nettype none

// A-weighting filter: three cascaded second-order IIR sections, fixed point.
// Input samples arrive as beats on the s_axis channel, one 24-bit two's
// complement sample per beat; weighted samples leave on m_axis, one per input.
// Coefficients, output gain and per-section shifts are written through the
// cfg channel (index 0..7, always ready); write them only while idle.
// Each sample passes, from acceptance to the next acceptance, through the
// idle state, a history read, the steps S1 to S7 for each section and the
// gain steps G1 to G3. Its length is set by the single shared multiplier,
// which forms every 48x33-bit coefficient product in two half-width passes,
// and by the one-row-per-cycle history RAM read and written back per section.
// The output register frees the input side: a new sample is taken while the
// previous result still waits. If the receiver stalls, the block finishes
// the next sample's sections and holds in its last step until the output
// register is free.
// Reset clears all filter history (through row valid bits), the denominator
// coefficients and shifts to zero and the output gain to 1.0.
module a_weighting_filter_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input stream; tdata[23:0] = sample_in
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [awf_pkg::SAMPLE_WIDTH-1:0]    s_axis_tdata,
    // Output stream; tdata[23:0] = weighted_out
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [awf_pkg::SAMPLE_WIDTH-1:0]         m_axis_tdata,
    // Configuration write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [awf_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  wire logic [awf_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    localparam int SW  = awf_pkg::STATE_WIDTH;
    localparam int OW  = awf_pkg::SAMPLE_WIDTH;
    localparam int SHW = awf_pkg::SHIFT_WIDTH;
    localparam int LW  = 1 << (SHW - 1);
    localparam logic [awf_pkg::SEC_IDX_WIDTH-1:0] LAST_SEC =
        awf_pkg::SEC_IDX_WIDTH'(awf_pkg::NUM_SECTIONS - 1);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_RD   = 12'b0000_0000_0010,
        ST_S1   = 12'b0000_0000_0100,
        ST_S2   = 12'b0000_0000_1000,
        ST_S3   = 12'b0000_0001_0000,
        ST_S4   = 12'b0000_0010_0000,
        ST_S5   = 12'b0000_0100_0000,
        ST_S6   = 12'b0000_1000_0000,
        ST_S7   = 12'b0001_0000_0000,
        ST_G1   = 12'b0010_0000_0000,
        ST_G2   = 12'b0100_0000_0000,
        ST_G3   = 12'b1000_0000_0000
    } t_state;

    // Saturating add to the state width
    function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] b);
        logic signed [SW:0] sum;
        sum = {a[SW-1], a} + {b[SW-1], b};
        if (sum[SW] != sum[SW-1]) begin
            sat_add = sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sat_add = sum[SW-1:0];
        end
    endfunction

    // Saturating subtract to the state width
    function automatic logic signed [SW-1:0] sat_sub(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] b);
        logic signed [SW:0] dif;
        dif = {a[SW-1], a} - {b[SW-1], b};
        if (dif[SW] != dif[SW-1]) begin
            sat_sub = dif[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sat_sub = dif[SW-1:0];
        end
    endfunction

    // Scale by 2^-s: floor right shift, or left shift saturating to the state width
    function automatic logic signed [SW-1:0] scale_pow2(input logic signed [SW-1:0] v,
                                                        input logic [SHW-1:0] s);
        logic signed [SW+LW-1:0] wide;
        logic [SHW-1:0]          n;
        logic [LW:0]             hi;
        n    = SHW'(-s);
        wide = (SW+LW)'(v) <<< n;
        hi   = wide[SW+LW-1:SW-1];
        if (!s[SHW-1]) begin
            scale_pow2 = v >>> s[SHW-2:0];
        end else if ((hi == '0) || (hi == '1)) begin
            scale_pow2 = wide[SW-1:0];
        end else begin
            scale_pow2 = wide[SW+LW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
    endfunction

    // Clamp a state-width value to the sample width
    function automatic logic [OW-1:0] clamp_out(input logic signed [SW-1:0] v);
        logic [SW-OW:0] hi;
        hi = v[SW-1:OW-1];
        if ((hi == '0) || (hi == '1)) begin
            clamp_out = v[OW-1:0];
        end else begin
            clamp_out = v[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end
    endfunction

    awf_pkg::t_cfg     cfg;
    awf_pkg::t_row     rd_row;
    awf_pkg::t_row     wr_row;
    awf_pkg::t_mul_op  mul_op;

    t_state r_state, n_state;
    logic [awf_pkg::SEC_IDX_WIDTH-1:0] r_sec, n_sec;
    logic signed [SW-1:0] r_u, n_u;
    logic signed [SW-1:0] r_v, n_v;
    logic signed [SW-1:0] r_acc, n_acc;
    logic signed [SW-1:0] r_prod, n_prod;
    logic [OW-1:0] r_out, n_out;
    logic r_out_vld, n_out_vld;

    logic                                   rd_en;
    logic [awf_pkg::SEC_IDX_WIDTH-1:0]      rd_addr;
    logic                                   wr_en;
    logic signed [SW-1:0]                   mul_y;
    logic signed [awf_pkg::NCOEF_WIDTH-1:0] mul_c;
    logic signed [SW-1:0]                   mul_prod;
    logic                                   out_free;
    logic                                   sec0;
    logic [awf_pkg::COEF_IDX_WIDTH-1:0]     c1_idx;
    logic [awf_pkg::COEF_IDX_WIDTH-1:0]     c2_idx;

    awf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    awf_state_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_row),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_sec),
        .i_wr_data (wr_row)
    );

    awf_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .i_y    (mul_y),
        .i_c    (mul_c),
        .o_prod (mul_prod)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign sec0          = (r_sec == '0);
    assign c1_idx        = {r_sec, 1'b0};
    assign c2_idx        = {r_sec, 1'b1};

    // Shift the history row on write-back
    assign wr_row.x1 = r_v;
    assign wr_row.x2 = rd_row.x1;
    assign wr_row.y1 = r_acc;
    assign wr_row.y2 = rd_row.y1;

    // Sequencer and datapath
    always_comb begin
        n_state   = r_state;
        n_sec     = r_sec;
        n_u       = r_u;
        n_v       = r_v;
        n_acc     = r_acc;
        n_prod    = r_prod;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        rd_en     = 1'b0;
        rd_addr   = r_sec;
        wr_en     = 1'b0;
        mul_op    = awf_pkg::MUL_HOLD;
        mul_y     = rd_row.y1;
        mul_c     = cfg.nden[c1_idx];

        // Drop the result once the receiver takes it
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_u     = SW'($signed(s_axis_tdata));
                    n_sec   = '0;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                rd_en   = 1'b1;
                n_state = ST_S1;
            end
            ST_S1: begin
                n_v     = scale_pow2(r_u, cfg.shifts[r_sec]);
                mul_op  = awf_pkg::MUL_LO;
                n_state = ST_S2;
            end
            ST_S2: begin
                mul_op  = awf_pkg::MUL_HI;
                n_acc   = sat_sub(r_v, sec0 ? rd_row.x1 : rd_row.x2);
                n_state = ST_S3;
            end
            ST_S3: begin
                n_prod  = mul_prod;
                mul_op  = awf_pkg::MUL_LO;
                mul_y   = rd_row.y2;
                mul_c   = cfg.nden[c2_idx];
                if (sec0) begin
                    n_acc = sat_sub(r_acc, rd_row.x1);
                end
                n_state = ST_S4;
            end
            ST_S4: begin
                mul_op  = awf_pkg::MUL_HI;
                mul_y   = rd_row.y2;
                mul_c   = cfg.nden[c2_idx];
                if (sec0) begin
                    n_acc = sat_add(r_acc, rd_row.x2);
                end
                n_state = ST_S5;
            end
            ST_S5: begin
                n_acc   = sat_add(r_acc, r_prod);
                n_prod  = mul_prod;
                n_state = ST_S6;
            end
            ST_S6: begin
                n_acc   = sat_add(r_acc, r_prod);
                n_state = ST_S7;
            end
            ST_S7: begin
                // Write back this section; fetch the next row unless this is the last section
                wr_en = 1'b1;
                n_u   = r_acc;
                if (r_sec == LAST_SEC) begin
                    n_sec   = '0;
                    n_state = ST_G1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_sec + 1'b1;
                    n_sec   = r_sec + 1'b1;
                    n_state = ST_S1;
                end
            end
            ST_G1: begin
                mul_op  = awf_pkg::MUL_LO;
                mul_y   = r_u;
                mul_c   = awf_pkg::NCOEF_WIDTH'($signed(cfg.gain));
                n_state = ST_G2;
            end
            ST_G2: begin
                mul_op  = awf_pkg::MUL_HI;
                mul_y   = r_u;
                mul_c   = awf_pkg::NCOEF_WIDTH'($signed(cfg.gain));
                n_state = ST_G3;
            end
            ST_G3: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_out     = clamp_out(mul_prod);
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sec     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sec     <= n_sec;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_u    <= n_u;
        r_v    <= n_v;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire
